[src/cdm_pkg.sv]
// ----------------------------------------------------------------------------
// cdm_pkg
// Types, constants and small lookup functions shared by the clock digit
// multiplexer driver modules.
// ----------------------------------------------------------------------------
package cdm_pkg;

  // depth of the queue between the front and back parts
  localparam int unsigned QueueDepth = 2;

  // configuration register indexes
  localparam logic [1:0] RegDwellFloor = 2'd0;
  localparam logic [1:0] RegDwellSwing = 2'd1;
  localparam logic [1:0] RegMaxReading = 2'd2;

  // configuration reset values
  localparam logic [10:0] DwellFloorRst = 11'd30;
  localparam logic [10:0] DwellSwingRst = 11'd60;
  localparam logic [11:0] MaxReadingRst = 12'd3000;

  // divider: quotient bits produced per cycle and total quotient bits
  localparam int unsigned DivStepBits = 4;
  localparam int unsigned DivQuoBits  = 12;
  localparam int unsigned DivRounds   = DivQuoBits / DivStepBits;

  // index of the final drive state of a refresh
  localparam logic [2:0] LastStep = 3'd4;

  typedef enum logic [1:0] {
    FR_IDLE,
    FR_DIV,
    FR_DONE
  } cdm_front_state_t;

  typedef struct packed {
    logic [10:0] dwell_floor;
    logic [10:0] dwell_swing;
    logic [11:0] max_reading;
  } cdm_cfg_t;

  typedef struct packed {
    logic        ad_on;
    logic [3:0]  h_units;
    logic [3:0]  m_tens;
    logic [3:0]  m_units;
    logic [11:0] dwell;
  } cdm_job_t;

  // returns {tens % 10, units} of a 7-bit value, divide by 10 via reciprocal
  function automatic logic [7:0] split_digits(input logic [6:0] v);
    logic [14:0] p;
    logic [3:0]  t;
    logic [6:0]  u;
    p = 15'(v) * 15'd205;
    t = p[14:11];
    u = v - 7'(7'(t) * 7'd10);
    if (t >= 4'd10) begin
      t = t - 4'd10;
    end
    return {t, u[3:0]};
  endfunction

  // floor(x / 3) for 12-bit x
  function automatic logic [10:0] third_of(input logic [11:0] x);
    logic [23:0] p;
    p = 24'(x) * 24'd2731;
    return p[23:13];
  endfunction

  function automatic logic [15:0] seg_a(input logic [3:0] d);
    logic [15:0] m;
    case (d)
      4'd0:    m = 16'h0F00;
      4'd1:    m = 16'h0200;
      4'd2:    m = 16'h1500;
      4'd3:    m = 16'h1300;
      4'd4:    m = 16'h1A00;
      4'd5:    m = 16'h1B00;
      4'd6:    m = 16'h1F00;
      4'd7:    m = 16'h0200;
      4'd8:    m = 16'h1F00;
      4'd9:    m = 16'h1B00;
      default: m = 16'h0000;
    endcase
    return m;
  endfunction

  function automatic logic [15:0] seg_b(input logic [3:0] d);
    logic [15:0] m;
    case (d)
      4'd0:    m = 16'hC000;
      4'd1:    m = 16'h8000;
      4'd2:    m = 16'hC000;
      4'd3:    m = 16'hC000;
      4'd4:    m = 16'h8000;
      4'd5:    m = 16'h4000;
      4'd6:    m = 16'h4000;
      4'd7:    m = 16'hC000;
      4'd8:    m = 16'hC000;
      4'd9:    m = 16'hC000;
      default: m = 16'h0000;
    endcase
    return m;
  endfunction

endpackage

[src/cdm_front.sv]
// ----------------------------------------------------------------------------
// cdm_front
// Accepts refresh requests, splits the digits and computes the dwell time
// with a multiply and an iterative restoring divider.
// ----------------------------------------------------------------------------
module cdm_front (
  input  logic               clk,
  input  logic               rst,
  input  cdm_pkg::cdm_cfg_t  cfg,
  input  logic               push,
  input  logic [6:0]         hours,
  input  logic [6:0]         minutes,
  input  logic [11:0]        brightness,
  output logic               in_ready,
  input  logic               q_full,
  output logic               q_push,
  output cdm_pkg::cdm_job_t  q_job
);

  localparam int unsigned StepW = $clog2(cdm_pkg::DivRounds);

  cdm_pkg::cdm_front_state_t state, state_next;

  logic [22:0] prod;
  logic        accept;
  logic [7:0]  hsplit;
  logic [7:0]  msplit;

  logic [StepW-1:0]                step;
  logic [11:0]                     rem;
  logic [cdm_pkg::DivQuoBits-1:0]  lo;
  logic [cdm_pkg::DivQuoBits-1:0]  quo;
  logic                            sat;
  logic                            ad_on;
  logic [3:0]                      h_units;
  logic [3:0]                      m_tens;
  logic [3:0]                      m_units;

  logic [11:0]                     rem_next;
  logic [cdm_pkg::DivQuoBits-1:0]  lo_next;
  logic [cdm_pkg::DivQuoBits-1:0]  quo_next;

  assign prod   = 23'(cfg.dwell_swing) * 23'(brightness);
  assign accept = push && in_ready;
  assign hsplit = cdm_pkg::split_digits(hours);
  assign msplit = cdm_pkg::split_digits(minutes);

  always_comb begin
    state_next = state;
    case (state)
      cdm_pkg::FR_IDLE: begin
        if (accept) state_next = cdm_pkg::FR_DIV;
      end
      cdm_pkg::FR_DIV: begin
        if (step == StepW'(cdm_pkg::DivRounds - 1)) state_next = cdm_pkg::FR_DONE;
      end
      cdm_pkg::FR_DONE: begin
        if (!q_full) state_next = accept ? cdm_pkg::FR_DIV : cdm_pkg::FR_IDLE;
      end
      default: state_next = cdm_pkg::FR_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    q_push   = 1'b0;
    case (state)
      cdm_pkg::FR_IDLE: in_ready = 1'b1;
      cdm_pkg::FR_DONE: begin
        q_push   = !q_full;
        in_ready = !q_full;
      end
      default: begin
        in_ready = 1'b0;
        q_push   = 1'b0;
      end
    endcase
  end

  // DivStepBits restoring divide steps per cycle, remainder stays below the divisor
  always_comb begin
    logic [12:0] t;
    rem_next = rem;
    lo_next  = lo;
    quo_next = quo;
    for (int i = 0; i < int'(cdm_pkg::DivStepBits); i++) begin
      t       = {rem_next, lo_next[cdm_pkg::DivQuoBits-1]};
      lo_next = {lo_next[cdm_pkg::DivQuoBits-2:0], 1'b0};
      if (t >= {1'b0, cfg.max_reading}) begin
        rem_next = 12'(t - {1'b0, cfg.max_reading});
        quo_next = {quo_next[cdm_pkg::DivQuoBits-2:0], 1'b1};
      end else begin
        rem_next = t[11:0];
        quo_next = {quo_next[cdm_pkg::DivQuoBits-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cdm_pkg::FR_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      step    <= '0;
      rem     <= {1'b0, prod[22:12]};
      lo      <= prod[11:0];
      quo     <= '0;
      // covers a zero max_reading as well
      sat     <= brightness >= cfg.max_reading;
      ad_on   <= hsplit[7:4] == 4'd1;
      h_units <= hsplit[3:0];
      m_tens  <= msplit[7:4];
      m_units <= msplit[3:0];
    end else if (state == cdm_pkg::FR_DIV) begin
      step <= step + StepW'(1);
      rem  <= rem_next;
      lo   <= lo_next;
      quo  <= quo_next;
    end
  end

  always_comb begin
    q_job.ad_on   = ad_on;
    q_job.h_units = h_units;
    q_job.m_tens  = m_tens;
    q_job.m_units = m_units;
    q_job.dwell   = {1'b0, cfg.dwell_floor}
                  + (sat ? {1'b0, cfg.dwell_swing} : {1'b0, quo[10:0]});
  end

endmodule

[src/cdm_fifo.sv]
// ----------------------------------------------------------------------------
// cdm_fifo
// Short register queue holding dwell jobs between the front and back parts.
// ----------------------------------------------------------------------------
module cdm_fifo #(
  parameter int unsigned DEPTH = cdm_pkg::QueueDepth
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  cdm_pkg::cdm_job_t din,
  output logic              full,
  input  logic              pop,
  output cdm_pkg::cdm_job_t dout,
  output logic              valid
);

  localparam int unsigned PtrW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  cdm_pkg::cdm_job_t mem [DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  assign full  = count == CntW'(DEPTH);
  assign valid = count != '0;
  assign dout  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + PtrW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + PtrW'(1);
      end
      if (push && !pop) begin
        count <= count + CntW'(1);
      end else if (pop && !push) begin
        count <= count - CntW'(1);
      end
    end
  end

endmodule

[src/cdm_back.sv]
// ----------------------------------------------------------------------------
// cdm_back
// Sequences the five drive states of each job into the output register.
// ----------------------------------------------------------------------------
module cdm_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  cdm_pkg::cdm_job_t q_job,
  output logic              q_pop,
  input  logic              pop,
  output logic              empty,
  output logic [1:0]        digit_index,
  output logic [15:0]       port_a_mask,
  output logic [15:0]       port_b_mask,
  output logic              lead_ad_on,
  output logic              lead_bc_on,
  output logic [11:0]       hold_count,
  output logic              last
);

  logic              cur_valid;
  cdm_pkg::cdm_job_t cur;
  logic [10:0]       cur_third;
  logic [2:0]        step;
  logic              out_valid;
  logic              adv;
  logic [3:0]        digit;

  assign empty = !out_valid;
  assign adv   = cur_valid && (!out_valid || pop);
  assign q_pop = q_valid && (!cur_valid || (adv && step == cdm_pkg::LastStep));

  always_comb begin
    case (step)
      3'd2:    digit = cur.h_units;
      3'd3:    digit = cur.m_tens;
      default: digit = cur.m_units;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (q_pop) begin
        cur_valid <= 1'b1;
      end else if (adv && step == cdm_pkg::LastStep) begin
        cur_valid <= 1'b0;
      end
      if (adv) begin
        step <= (step == cdm_pkg::LastStep) ? '0 : step + 3'd1;
      end
      if (adv) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur       <= q_job;
      cur_third <= cdm_pkg::third_of(q_job.dwell);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      case (step)
        3'd0: begin
          digit_index <= 2'd0;
          port_a_mask <= '0;
          port_b_mask <= '0;
          lead_ad_on  <= cur.ad_on;
          lead_bc_on  <= 1'b1;
          hold_count  <= {1'b0, cur_third};
          last        <= 1'b0;
        end
        3'd1: begin
          digit_index <= 2'd0;
          port_a_mask <= '0;
          port_b_mask <= '0;
          lead_ad_on  <= cur.ad_on;
          lead_bc_on  <= 1'b0;
          hold_count  <= {cur_third, 1'b0};
          last        <= 1'b0;
        end
        default: begin
          digit_index <= 2'(step - 3'd1);
          port_a_mask <= cdm_pkg::seg_a(digit);
          port_b_mask <= cdm_pkg::seg_b(digit);
          lead_ad_on  <= 1'b0;
          lead_bc_on  <= 1'b0;
          hold_count  <= cur.dwell;
          last        <= step == cdm_pkg::LastStep;
        end
      endcase
    end
  end

endmodule

[src/clock_digit_mux_driver.sv]
// ----------------------------------------------------------------------------
// clock_digit_mux_driver
// Four-digit multiplexed clock display driver with brightness-scaled dwell.
// ----------------------------------------------------------------------------
// Each refresh request (hours, minutes, brightness) yields five drive states
// at the output register: two for the leading digit (B/C lit for dwell/3,
// then dropped for twice that), then hours-units, minutes-tens and
// minutes-units each held for the full dwell. The back sequencer issues one
// drive state a cycle while the consumer keeps popping. The front multiplies
// on accept, then runs a four-bit-per-cycle divider and takes no new request
// while dividing; it can take the next as it pushes the job into the
// two-entry queue that feeds the back. Registers may be written only while
// no request is in flight.
module clock_digit_mux_driver #(
  parameter int unsigned QUEUE_DEPTH = cdm_pkg::QueueDepth
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [11:0] cfg_data,
  input  logic        push,
  output logic        full,
  input  logic [6:0]  hours,
  input  logic [6:0]  minutes,
  input  logic [11:0] brightness,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  digit_index,
  output logic [15:0] port_a_mask,
  output logic [15:0] port_b_mask,
  output logic        lead_ad_on,
  output logic        lead_bc_on,
  output logic [11:0] hold_count,
  output logic        last
);

  cdm_pkg::cdm_cfg_t cfg;
  cdm_pkg::cdm_job_t push_job;
  cdm_pkg::cdm_job_t head_job;
  logic              in_ready;
  logic              q_full;
  logic              q_push;
  logic              q_valid;
  logic              q_pop;

  assign cfg_ready = 1'b1;
  assign full      = !in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dwell_floor <= cdm_pkg::DwellFloorRst;
      cfg.dwell_swing <= cdm_pkg::DwellSwingRst;
      cfg.max_reading <= cdm_pkg::MaxReadingRst;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        cdm_pkg::RegDwellFloor: cfg.dwell_floor <= cfg_data[10:0];
        cdm_pkg::RegDwellSwing: cfg.dwell_swing <= cfg_data[10:0];
        cdm_pkg::RegMaxReading: cfg.max_reading <= cfg_data;
        default: ;
      endcase
    end
  end

  cdm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .push       (push),
    .hours      (hours),
    .minutes    (minutes),
    .brightness (brightness),
    .in_ready   (in_ready),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_job      (push_job)
  );

  cdm_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (push_job),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (head_job),
    .valid (q_valid)
  );

  cdm_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_job       (head_job),
    .q_pop       (q_pop),
    .pop         (pop),
    .empty       (empty),
    .digit_index (digit_index),
    .port_a_mask (port_a_mask),
    .port_b_mask (port_b_mask),
    .lead_ad_on  (lead_ad_on),
    .lead_bc_on  (lead_bc_on),
    .hold_count  (hold_count),
    .last        (last)
  );

  // queue never written while full
  assert property (@(posedge clk) disable iff (rst) q_push |-> !q_full)
    else $error("job queue overflow");

  // queue never read while empty
  assert property (@(posedge clk) disable iff (rst) q_pop |-> q_valid)
    else $error("job queue underflow");

  // final state of a refresh is always the minutes-units digit
  assert property (@(posedge clk) disable iff (rst)
    (!empty && last) |-> (digit_index == 2'd3 && !lead_bc_on))
    else $error("last flag on wrong digit");

  // leading B/C state belongs to the leading digit with blank port masks
  assert property (@(posedge clk) disable iff (rst)
    (!empty && lead_bc_on) |-> (digit_index == 2'd0 && port_a_mask == '0))
    else $error("lead b/c on wrong digit");

endmodule
